// ===== rtl/core/tep_pkg.sv =====
// Shared types, codes and constants of the tile edge padder.
`default_nettype none

package tep_pkg;

    // Default geometry limits of the padded tile
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 4096;

    // Field widths
    localparam int PIX_W  = 32;
    localparam int SW_W   = 11;
    localparam int SH_W   = 13;
    localparam int CFG_W  = 13;
    localparam int IDX_W  = 3;
    localparam int STAT_W = 2;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_SRC_W = 3'd0;
    localparam logic [IDX_W-1:0] REG_SRC_H = 3'd1;
    localparam logic [IDX_W-1:0] REG_TGT_W = 3'd2;
    localparam logic [IDX_W-1:0] REG_TGT_H = 3'd3;
    localparam logic [IDX_W-1:0] REG_COPY  = 3'd4;

    // Configuration reset values
    localparam logic [SW_W-1:0] SRC_W_RST = 11'd4;
    localparam logic [SH_W-1:0] SRC_H_RST = 13'd4;
    localparam logic [SW_W-1:0] TGT_W_RST = 11'd4;
    localparam logic [SH_W-1:0] TGT_H_RST = 13'd4;
    localparam logic            COPY_RST  = 1'b1;

    // Input commands
    localparam logic CMD_SOURCE = 1'b0;
    localparam logic CMD_PAD    = 1'b1;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK   = 2'd0,
        ST_SIZE = 2'd1,
        ST_CMD  = 2'd2
    } tep_status_t;

    // Where the back end takes the pixel from
    typedef enum logic [1:0] {
        PX_SOURCE = 2'd0,
        PX_ZERO   = 2'd1,
        PX_PREV   = 2'd2,
        PX_LINE   = 2'd3
    } tep_kind_t;

    // Classified item handed from front to back
    typedef struct packed {
        tep_kind_t          kind;
        tep_status_t        status;
        logic               tile_end;
        logic [PIX_W-1:0]   pixel;
    } tep_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/tep_front.sv =====
// Front end: configuration registers, output position and item classification.
`default_nettype none

module tep_front #(
    parameter int  MAX_WIDTH  = tep_pkg::MAX_WIDTH_DEF,
    parameter int  MAX_HEIGHT = tep_pkg::MAX_HEIGHT_DEF,
    localparam int COL_W      = $clog2(MAX_WIDTH),
    localparam int ROW_W      = $clog2(MAX_HEIGHT)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [tep_pkg::IDX_W-1:0]   cfg_index,
    input  logic [tep_pkg::CFG_W-1:0]   cfg_data,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [tep_pkg::PIX_W-1:0]   s_tdata,
    input  logic                        s_tuser,
    output logic                        push,
    output tep_pkg::tep_cmd_t           cmd,
    output logic [COL_W-1:0]            col
);
    import tep_pkg::*;

    logic [SW_W-1:0]  sw_reg;
    logic [SH_W-1:0]  sh_reg;
    logic [SW_W-1:0]  tw_reg;
    logic [SH_W-1:0]  th_reg;
    logic             copy_reg;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             sizes_ok;
    logic             in_source;
    logic             col_last;
    logic             row_last;
    logic             step;

    assign cfg_ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sw_reg   <= SRC_W_RST;
            sh_reg   <= SRC_H_RST;
            tw_reg   <= TGT_W_RST;
            th_reg   <= TGT_H_RST;
            copy_reg <= COPY_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_SRC_W: sw_reg   <= cfg_data[SW_W-1:0];
                REG_SRC_H: sh_reg   <= cfg_data[SH_W-1:0];
                REG_TGT_W: tw_reg   <= cfg_data[SW_W-1:0];
                REG_TGT_H: th_reg   <= cfg_data[SH_W-1:0];
                REG_COPY:  copy_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Classify the item at the current position
    always_comb begin
        sizes_ok = (sw_reg != '0) && (sh_reg != '0) && (tw_reg >= sw_reg) &&
                   (th_reg >= sh_reg) && (32'(tw_reg) <= 32'(MAX_WIDTH)) &&
                   (32'(th_reg) <= 32'(MAX_HEIGHT));
        in_source = (32'(col_reg) < 32'(sw_reg)) && (32'(row_reg) < 32'(sh_reg));
        col_last  = (32'(col_reg) + 32'd1) >= 32'(tw_reg);
        row_last  = (32'(row_reg) + 32'd1) >= 32'(th_reg);

        cmd.kind     = PX_ZERO;
        cmd.status   = ST_OK;
        cmd.tile_end = 1'b0;
        cmd.pixel    = s_tdata;
        if (!sizes_ok) begin
            cmd.status = ST_SIZE;
        end else if (in_source != (s_tuser == CMD_SOURCE)) begin
            cmd.status = ST_CMD;
        end else begin
            cmd.tile_end = col_last && row_last;
            if (in_source) begin
                cmd.kind = PX_SOURCE;
            end else if (!copy_reg) begin
                cmd.kind = PX_ZERO;
            end else if (32'(row_reg) < 32'(sh_reg)) begin
                cmd.kind = PX_PREV;
            end else begin
                cmd.kind = PX_LINE;
            end
        end
    end

    assign push = s_tvalid && s_tready;
    assign col  = col_reg;
    assign step = push && (cmd.status == ST_OK);

    // Advance the raster position
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (step) begin
            if (col_last) begin
                col_next = '0;
                row_next = row_last ? '0 : row_reg + ROW_W'(1);
            end else begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/tep_queue.sv =====
// Short FIFO between the classifying front end and the pixel back end.
`default_nettype none

module tep_queue #(
    parameter int DATA_W = 40
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    output logic              push_ready,
    input  logic [DATA_W-1:0] push_data,
    output logic              pop_valid,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data
);
    import tep_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_W-1:0] entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed item
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/tep_back.sv =====
// Back end: line store, pixel selection and the output register.
`default_nettype none

module tep_back #(
    parameter int  MAX_WIDTH = tep_pkg::MAX_WIDTH_DEF,
    localparam int COL_W     = $clog2(MAX_WIDTH)
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         q_valid,
    output logic                         q_pop,
    input  tep_pkg::tep_cmd_t            q_cmd,
    input  logic [COL_W-1:0]             q_col,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [tep_pkg::PIX_W-1:0]    m_tdata,
    output logic                         m_tlast,
    output logic [tep_pkg::STAT_W-1:0]   m_tuser
);
    import tep_pkg::*;

    logic [PIX_W-1:0]  line_store_reg [MAX_WIDTH];
    logic              a_valid_reg, a_valid_next;
    tep_cmd_t          a_cmd_reg;
    logic [COL_W-1:0]  a_col_reg;
    logic [PIX_W-1:0]  line_rd_reg;
    logic              byp_hit_reg;
    logic [PIX_W-1:0]  byp_data_reg;
    logic [PIX_W-1:0]  prev_reg;
    logic              b_valid_reg, b_valid_next;
    logic [PIX_W-1:0]  b_pixel_reg;
    logic              b_last_reg;
    tep_status_t       b_status_reg;
    logic              a_move;
    logic              a_load;
    logic              wr_en;
    logic [PIX_W-1:0]  line_pix;
    logic [PIX_W-1:0]  pix;

    // Handshakes between the queue, the read stage and the output register
    assign a_move = a_valid_reg && (!b_valid_reg || m_tready);
    assign q_pop  = q_valid && (!a_valid_reg || a_move);
    assign a_load = q_pop;
    assign wr_en  = a_move && (a_cmd_reg.status == ST_OK);

    // Select the pixel of the item in the read stage
    always_comb begin
        line_pix = byp_hit_reg ? byp_data_reg : line_rd_reg;
        case (a_cmd_reg.kind)
            PX_SOURCE: pix = a_cmd_reg.pixel;
            PX_ZERO:   pix = '0;
            PX_PREV:   pix = prev_reg;
            PX_LINE:   pix = line_pix;
            default:   pix = '0;
        endcase
    end

    // Write the line store; read ahead, catching a write to the same column
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_store_reg[a_col_reg] <= pix;
        end
        if (a_load) begin
            line_rd_reg  <= line_store_reg[q_col];
            byp_hit_reg  <= wr_en && (a_col_reg == q_col);
            byp_data_reg <= pix;
        end
    end

    // Load the read stage
    always_comb begin
        a_valid_next = a_valid_reg;
        if (a_load) begin
            a_valid_next = 1'b1;
        end else if (a_move) begin
            a_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_load) begin
            a_cmd_reg <= q_cmd;
            a_col_reg <= q_col;
        end
    end

    // Hold the last pixel emitted with ok status
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg <= '0;
        end else if (wr_en) begin
            prev_reg <= pix;
        end
    end

    // Output register
    always_comb begin
        b_valid_next = b_valid_reg;
        if (a_move) begin
            b_valid_next = 1'b1;
        end else if (m_tready) begin
            b_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_move) begin
            b_pixel_reg  <= pix;
            b_last_reg   <= a_cmd_reg.tile_end;
            b_status_reg <= a_cmd_reg.status;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    assign m_tvalid = b_valid_reg;
    assign m_tdata  = b_pixel_reg;
    assign m_tlast  = b_last_reg;
    assign m_tuser  = b_status_reg;

endmodule

`default_nettype wire

// ===== rtl/core/tile_edge_pad.sv =====
// Top level of the tile edge padder: front end, queue and back end.
//
// Pads a tile of 32-bit pixels out to target_width x target_height in raster
// order. Each input item on the s_ channel gives one result item on the m_
// channel. s_tuser says what the item is: 0 carries a source pixel in s_tdata,
// 1 asks for a padding pixel. m_tdata is the pixel, m_tlast marks the last
// pixel of the padded tile, m_tuser is the status (0 ok, 1 bad sizes, 2 the
// command does not fit the position); an error result carries pixel zero and
// leaves the position alone.
// Registers are written on the cfg_ channel (cfg_ready is always high); the user
// writes them only while no item is in flight, which the block does not enforce.
// Throughput is one item per cycle while m_tready stays high; an accepted item
// passes the queue entry, the line-store read and the output register on its way out.
// The line store is read ahead of use into a register, with a bypass for a write to
// the same column; that registered read sets the read stage.
// When m_tready is low the output register holds and the read stage and the
// two-entry queue fill; s_tready falls once four items wait inside.
// Reset (aresetn low, synchronous) returns the position to the tile origin,
// loads 4, 4, 4, 4 and copy mode into the registers and empties the pipe; the
// line store is not cleared and is written before any vertical copy reads it.
`default_nettype none

module tile_edge_pad #(
    parameter int  MAX_WIDTH  = tep_pkg::MAX_WIDTH_DEF,
    parameter int  MAX_HEIGHT = tep_pkg::MAX_HEIGHT_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // configuration write channel
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [tep_pkg::IDX_W-1:0]    cfg_index,
    input  logic [tep_pkg::CFG_W-1:0]    cfg_data,
    // input items
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [tep_pkg::PIX_W-1:0]    s_tdata,   // [31:0] source_pixel
    input  logic                         s_tuser,   // [0] command
    // result items
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [tep_pkg::PIX_W-1:0]    m_tdata,   // [31:0] out_pixel
    output logic                         m_tlast,   // tile_end
    output logic [tep_pkg::STAT_W-1:0]   m_tuser    // [1:0] status
);
    import tep_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int Q_W   = $bits(tep_cmd_t) + COL_W;

    logic             push;
    tep_cmd_t         f_cmd;
    logic [COL_W-1:0] f_col;
    logic             q_valid;
    logic             q_pop;
    logic [Q_W-1:0]   q_data;
    tep_cmd_t         q_cmd;
    logic [COL_W-1:0] q_col;

    tep_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .push      (push),
        .cmd       (f_cmd),
        .col       (f_col)
    );

    tep_queue #(
        .DATA_W (Q_W)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_ready (s_tready),
        .push_data  ({f_cmd, f_col}),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_data   (q_data)
    );

    assign q_cmd = q_data[Q_W-1:COL_W];
    assign q_col = q_data[COL_W-1:0];

    tep_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_cmd    (q_cmd),
        .q_col    (q_col),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

// ===== rtl/core/tep_checker.sv =====
// Port-level checks of the tile edge padder and their binding to the top level.
`default_nettype none

module tep_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [tep_pkg::PIX_W-1:0]    m_tdata,
    input  logic                         m_tlast,
    input  logic [tep_pkg::STAT_W-1:0]   m_tuser
);
    import tep_pkg::*;

    // An error result carries a zero pixel and never ends the tile
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser != ST_OK)) |-> ((m_tdata == '0) && !m_tlast))
        else $error("error result with nonzero pixel or tile end");

    // Reset empties the output
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A stalled result holds its pixel
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result dropped or changed pixel");

    // A stalled result holds its tile end and status
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> ($stable(m_tlast) && $stable(m_tuser)))
        else $error("stalled result changed tile end or status");

endmodule

bind tile_edge_pad tep_checker u_tep_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the tile edge padder: stimulus, pixel prediction and result checks.
`timescale 1ns / 1ps

module tb_top;
    import tep_pkg::*;

    // Unused register slot, written once to show that it changes nothing
    localparam logic [IDX_W-1:0] REG_SPARE = 3'd7;

    localparam int COL_BITS = $clog2(MAX_WIDTH_DEF);

    typedef struct {
        logic             cmd;
        logic [PIX_W-1:0] pix;
    } tile_px_t;

    typedef struct {
        logic [PIX_W-1:0] pix;
        logic             last;
        tep_status_t      status;
    } pad_pixel_t;

    typedef struct {
        int unsigned col;
        int unsigned row;
    } walk_t;

    typedef enum {RX_OPEN, RX_COIN, RX_SLOW, RX_TOGGLE} rx_mode_t;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]  cfg_data  = '0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [PIX_W-1:0]  s_tdata   = '0;
    logic              s_tuser   = 1'b0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [PIX_W-1:0]  m_tdata;
    logic              m_tlast;
    logic [STAT_W-1:0] m_tuser;

    // Register shadow, shared by the item generator and the pixel predictor
    int unsigned src_w   = 32'(SRC_W_RST);
    int unsigned src_h   = 32'(SRC_H_RST);
    int unsigned tgt_w   = 32'(TGT_W_RST);
    int unsigned tgt_h   = 32'(TGT_H_RST);
    bit          copy_on = COPY_RST;

    // Predicted block state
    walk_t            pos = '{0, 0};
    logic [PIX_W-1:0] last_pix = '0;
    logic [PIX_W-1:0] line_copy [0:MAX_WIDTH_DEF-1];

    // Position as the generator will leave it once all queued items are taken
    walk_t plan = '{0, 0};

    tile_px_t   tile_feed[$];
    pad_pixel_t due_pixels[$];

    int       fed_count  = 0;
    int       err_count  = 0;
    logic     in_taken   = 1'b0;
    int       burst_left = 0;
    int       gap_left   = 0;
    int       stall_asks = 0;
    int       stall_done = 0;
    int       hold_left  = 0;
    int       seg_left   = 0;
    rx_mode_t seg_mode   = RX_OPEN;

    tile_edge_pad u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always #1 aclk = ~aclk;

    function automatic bit sizes_valid();
        return src_w > 0 && src_h > 0 && tgt_w >= src_w && tgt_h >= src_h &&
               tgt_w <= MAX_WIDTH_DEF && tgt_h <= MAX_HEIGHT_DEF;
    endfunction

    function automatic bit at_source(input walk_t w);
        return w.col < src_w && w.row < src_h;
    endfunction

    // Advance one position in raster order; return 1 when the tile wraps
    function automatic bit step_walk(inout walk_t w);
        if (w.col + 1 >= tgt_w) begin
            w.col = 0;
            if (w.row + 1 >= tgt_h) begin
                w.row = 0;
                return 1'b1;
            end
            w.row = w.row + 1;
        end else begin
            w.col = w.col + 1;
        end
        return 1'b0;
    endfunction

    // Work out the pixel that one accepted item produces and hold it
    function automatic void pad_predict(input logic cmd, input logic [PIX_W-1:0] src);
        pad_pixel_t       r;
        logic [PIX_W-1:0] pix;
        bit               in_src;
        r.pix    = '0;
        r.last   = 1'b0;
        r.status = ST_OK;
        in_src   = at_source(pos);
        if (!sizes_valid()) begin
            r.status = ST_SIZE;
        end else if (in_src != (cmd == CMD_SOURCE)) begin
            r.status = ST_CMD;
        end else begin
            if (in_src) begin
                pix = src;
            end else if (!copy_on) begin
                pix = '0;
            end else if (pos.row < src_h) begin
                pix = last_pix;
            end else begin
                pix = (pos.col < MAX_WIDTH_DEF) ? line_copy[COL_BITS'(pos.col)] : '0;
            end
            last_pix = pix;
            if (pos.col < MAX_WIDTH_DEF) begin
                line_copy[COL_BITS'(pos.col)] = pix;
            end
            r.pix  = pix;
            r.last = step_walk(pos);
        end
        due_pixels.push_back(r);
    endfunction

    function automatic logic [PIX_W-1:0] rand_pixel();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return 32'd1 << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    // Queue one item with the command the position calls for, or the other one
    task automatic queue_item(input bit wrong, input logic [PIX_W-1:0] pix);
        tile_px_t it;
        bit       src;
        src    = at_source(plan);
        it.cmd = (src ^ wrong) ? CMD_SOURCE : CMD_PAD;
        it.pix = pix;
        if (sizes_valid() && !wrong) begin
            void'(step_walk(plan));
        end
        tile_feed.push_back(it);
        fed_count++;
    endtask

    // Walk the rest of the current tile back to row zero
    task automatic finish_rows();
        while (sizes_valid() && plan.row != 0) begin
            queue_item(1'b0, rand_pixel());
        end
    endtask

    task automatic drain_wait();
        while (tile_feed.size() != 0 || s_tvalid || due_pixels.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        case (idx)
            REG_SRC_W: src_w   = 32'(val[SW_W-1:0]);
            REG_SRC_H: src_h   = 32'(val[SH_W-1:0]);
            REG_TGT_W: tgt_w   = 32'(val[SW_W-1:0]);
            REG_TGT_H: tgt_h   = 32'(val[SH_W-1:0]);
            REG_COPY:  copy_on = val[0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_geometry(input int unsigned sw, input int unsigned sh,
                                input int unsigned tw, input int unsigned th, input bit cp);
        write_reg(REG_SRC_W, CFG_W'(sw));
        write_reg(REG_SRC_H, CFG_W'(sh));
        write_reg(REG_TGT_W, CFG_W'(tw));
        write_reg(REG_TGT_H, CFG_W'(th));
        write_reg(REG_COPY, CFG_W'(cp));
    endtask

    // Feed items in bursts with random gaps; hold an item until it is taken
    always @(negedge aclk) begin : drive_items
        tile_px_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
        end else if (!s_tvalid || in_taken) begin
            if (gap_left > 0 || tile_feed.size() == 0) begin
                if (gap_left > 0) begin
                    gap_left--;
                end
                s_tvalid <= 1'b0;
            end else begin
                nxt = tile_feed.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= nxt.cmd;
                s_tdata  <= nxt.pix;
                if (burst_left <= 1) begin
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                             : $urandom_range(1, 24);
                    gap_left   = $urandom_range(1, 5);
                end else begin
                    burst_left--;
                end
            end
        end
    end

    // Pace the result side: random segments of stall patterns, plus long hold-offs on request
    always @(negedge aclk) begin : pace_results
        logic rdy;
        if (!aresetn) begin
            rdy = 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
        end else if (stall_done != stall_asks) begin
            stall_done++;
            hold_left = 150;
            rdy = 1'b0;
        end else begin
            if (seg_left == 0) begin
                seg_mode = rx_mode_t'($urandom_range(0, 3));
                seg_left = $urandom_range(4, 60);
            end
            seg_left--;
            case (seg_mode)
                RX_OPEN: rdy = 1'b1;
                RX_COIN: rdy = 1'($urandom_range(0, 1));
                RX_SLOW: rdy = ($urandom_range(0, 3) == 0);
                default: rdy = ~m_tready;
            endcase
        end
        m_tready <= rdy;
    end

    // Predict on input accept, then compare each result with the oldest prediction
    always @(posedge aclk) begin : check_pixels
        pad_pixel_t want;
        in_taken <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            pad_predict(s_tuser, s_tdata);
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (due_pixels.size() == 0) begin
                $display("%0t: unexpected result pixel %h last %b status %0d",
                         $time, m_tdata, m_tlast, m_tuser);
                err_count++;
            end else begin
                want = due_pixels.pop_front();
                if (m_tdata !== want.pix) begin
                    $display("%0t: pixel expected %h actual %h", $time, want.pix, m_tdata);
                    err_count++;
                end
                if (m_tlast !== want.last) begin
                    $display("%0t: tile end expected %b actual %b", $time, want.last, m_tlast);
                    err_count++;
                end
                if (m_tuser !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status, m_tuser);
                    err_count++;
                end
            end
        end
    end

    initial begin : stimulus
        int unsigned sw;
        int unsigned sh;
        int unsigned tw;
        int unsigned th;
        bit          cp;
        int          n;
        int          phase;
        int          goal;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset geometry is all source: take three pixels, then a pad request out of place
        queue_item(1'b0, '0);
        queue_item(1'b0, '1);
        queue_item(1'b0, 32'h5A5A_5A5A);
        queue_item(1'b1, 32'h1234_5678);
        drain_wait();

        // Shrink the row under the current column, then copy right and copy down
        set_geometry(1, 2, 2, 3, 1'b1);
        write_reg(REG_SPARE, '1);
        queue_item(1'b0, rand_pixel());
        queue_item(1'b1, rand_pixel());
        queue_item(1'b0, 32'hC0FF_EE00);
        repeat (3) queue_item(1'b0, rand_pixel());
        drain_wait();

        // Same tile with zero padding, source item offered at a padding position
        write_reg(REG_COPY, '0);
        queue_item(1'b0, 32'h8000_0001);
        queue_item(1'b1, 32'hFFFF_0000);
        repeat (5) queue_item(1'b0, rand_pixel());
        drain_wait();

        // Bad sizes, register extremes among them
        set_geometry(0, 1, 1, 1, 1'b1);
        queue_item(1'b0, rand_pixel());
        drain_wait();
        set_geometry(2047, 8191, 2047, 8191, 1'b0);
        queue_item(1'b1, rand_pixel());
        drain_wait();
        set_geometry(1, 1, 1025, 1, 1'b1);
        queue_item(1'b0, rand_pixel());
        drain_wait();
        set_geometry(3, 4096, 2, 4096, 1'b1);
        queue_item(1'b0, rand_pixel());
        drain_wait();
        set_geometry(1, 1, 1, 4097, 1'b1);
        queue_item(1'b0, rand_pixel());
        drain_wait();
        set_geometry(1, 2, 1, 1, 1'b1);
        queue_item(1'b1, rand_pixel());
        drain_wait();

        // Widest row, one source row per tile, filling every line store column
        set_geometry(1024, 1, 1024, 1, 1'b1);
        repeat (1024) queue_item(1'b0, rand_pixel());
        drain_wait();

        // Largest valid tile: walk into the first row only
        set_geometry(1024, 4096, 1024, 4096, 1'b0);
        repeat (30) queue_item($urandom_range(0, 9) == 0, rand_pixel());
        drain_wait();

        // Random tiles, sizes changed only while the position sits on row zero
        goal  = fed_count + 700;
        phase = 0;
        while (fed_count < goal || phase < 7) begin
            sw = $urandom_range(1, 8);
            sh = $urandom_range(1, 6);
            tw = sw + $urandom_range(0, 6);
            th = sh + $urandom_range(0, 5);
            case ($urandom_range(0, 9))
                0: begin
                    sw = $urandom_range(1, 40);
                    tw = sw + $urandom_range(0, 30);
                end
                1: begin
                    case ($urandom_range(0, 3))
                        0: sw = 0;
                        1: sh = 0;
                        2: tw = sw - 1;
                        default: th = sh - 1;
                    endcase
                end
                default: ;
            endcase
            cp = 1'($urandom_range(0, 1));
            set_geometry(sw, sh, tw, th, cp);
            n = (phase == 3) ? 240 : $urandom_range(10, 80);
            repeat (n) queue_item($urandom_range(0, 19) == 0, rand_pixel());
            // Stall results long enough to back up the input
            if (phase == 3) begin
                stall_asks++;
            end
            // Pause the input until every pending result is out
            if (phase == 6) begin
                drain_wait();
                repeat (n) queue_item($urandom_range(0, 19) == 0, rand_pixel());
            end
            finish_rows();
            drain_wait();
            phase++;
        end

        repeat (20) @(posedge aclk);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("%0t: run did not finish in time", $time);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
